/* hw/rtl/canonical_kmer_dedup_extractor_assert.svh */
// Assertion helpers, clocked on clk and held off during rst.
`ifndef CANONICAL_KMER_DEDUP_EXTRACTOR_ASSERT_SVH
`define CANONICAL_KMER_DEDUP_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define CKDE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CKDE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ckde_pkg.sv */
`timescale 1ns / 1ps
package ckde_pkg;

  localparam int SEEN_DEPTH = 256;
  localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
  localparam int CNT_W      = $clog2(SEEN_DEPTH + 1);
  localparam int MAX_K      = 31;
  localparam int LEN_W      = 5;
  localparam int KMER_W     = 2 * MAX_K;
  localparam int SHIFT_W    = LEN_W + 1;
  localparam int DCOUNT_W   = 9;
  localparam int CHAR_W     = 8;

  localparam logic [LEN_W-1:0] KMER_LEN_RESET = LEN_W'(20);

  localparam logic [CHAR_W-1:0] CHAR_A_UC = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C_UC = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G_UC = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T_UC = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_A_LC = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_C_LC = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_G_LC = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_T_LC = 8'h74;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;
  localparam logic [1:0] COMP_XOR = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_PUT_KMER,
    ST_PUT_END
  } ckde_state_t;

  typedef struct packed {
    logic accept;
    logic search_start;
    logic search_step;
    logic commit;
    logic load_kmer;
    logic load_end;
  } ckde_cmd_t;

  typedef struct packed {
    logic full_kmer;
    logic last;
    logic count_zero;
    logic hit;
    logic miss_done;
    logic out_free;
  } ckde_stat_t;

  // {valid, code}
  function automatic logic [2:0] base_decode(input logic [CHAR_W-1:0] ch);
    logic [2:0] r;
    case (ch)
      CHAR_A_UC, CHAR_A_LC: r = {1'b1, CODE_A};
      CHAR_C_UC, CHAR_C_LC: r = {1'b1, CODE_C};
      CHAR_G_UC, CHAR_G_LC: r = {1'b1, CODE_G};
      CHAR_T_UC, CHAR_T_LC: r = {1'b1, CODE_T};
      default:              r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/ckde_ctrl.sv */
`timescale 1ns / 1ps
`include "canonical_kmer_dedup_extractor_assert.svh"
module ckde_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ckde_pkg::ckde_stat_t stat,
  output ckde_pkg::ckde_cmd_t  cmd
);
  import ckde_pkg::*;

  ckde_state_t state;
  ckde_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.full_kmer) begin
          state_next = stat.count_zero ? ST_PUT_KMER : ST_SEARCH;
        end else begin
          state_next = stat.last ? ST_PUT_END : ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (stat.hit) begin
          state_next = stat.last ? ST_PUT_END : ST_IDLE;
        end else if (stat.miss_done) begin
          state_next = ST_PUT_KMER;
        end
      end
      ST_PUT_KMER: begin
        if (stat.out_free) state_next = stat.last ? ST_PUT_END : ST_IDLE;
      end
      ST_PUT_END: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK: begin
        cmd.search_start = stat.full_kmer && !stat.count_zero;
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
      end
      ST_PUT_KMER: begin
        cmd.commit    = stat.out_free;
        cmd.load_kmer = stat.out_free;
      end
      ST_PUT_END: begin
        cmd.load_end = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `CKDE_ASSERT_NXT(a_accept_to_check, cmd.accept, state == ST_CHECK, "accepted word not checked")
  `CKDE_ASSERT_NXT(a_hit_no_emit, state == ST_SEARCH && stat.hit,
                   state == ST_PUT_END || state == ST_IDLE, "duplicate k-mer emitted")

endmodule

/* hw/rtl/ckde_dp.sv */
`timescale 1ns / 1ps
`include "canonical_kmer_dedup_extractor_assert.svh"
module ckde_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ckde_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic [ckde_pkg::CHAR_W-1:0]    base_char,
  input  logic                           first_of_read,
  input  logic                           last_of_read,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ckde_pkg::KMER_W-1:0]    kmer_value,
  output logic [ckde_pkg::DCOUNT_W-1:0]  distinct_count,
  output logic                           read_end,
  output logic                           store_overflow,
  input  ckde_pkg::ckde_cmd_t            cmd,
  output ckde_pkg::ckde_stat_t           stat
);
  import ckde_pkg::*;

  logic [LEN_W-1:0]  kmer_len;
  logic [KMER_W-1:0] fwd;
  logic [KMER_W-1:0] rev;
  logic [LEN_W-1:0]  run;
  logic [CNT_W-1:0]  count;
  logic              overflow;
  logic [KMER_W-1:0] canon;
  logic              full_kmer;
  logic              last_flag;
  logic [CNT_W-1:0]  ridx;
  logic              cmp_valid;
  logic              cmp_last;
  logic [KMER_W-1:0] rd_data;
  logic [KMER_W-1:0] mem [SEEN_DEPTH];

  logic [LEN_W-1:0]   k;
  logic [SHIFT_W-1:0] sh_mask;
  logic [SHIFT_W-1:0] sh_high;
  logic [KMER_W-1:0]  kmask;
  logic [2:0]         dec;
  logic               bvalid;
  logic [1:0]         code;
  logic [KMER_W-1:0]  f0;
  logic [KMER_W-1:0]  r0;
  logic [LEN_W-1:0]   run0;
  logic [LEN_W-1:0]   run_inc;
  logic [KMER_W-1:0]  fwd_shift;
  logic [KMER_W-1:0]  rev_shift;
  logic [KMER_W-1:0]  fwd_next;
  logic [KMER_W-1:0]  rev_next;
  logic [LEN_W-1:0]   run_next;
  logic               full_next;
  logic [KMER_W-1:0]  canon_next;
  logic               count_room;
  logic [CNT_W-1:0]   count_upd;
  logic               ovf_upd;
  logic               hit;

  always_comb begin
    if (kmer_len == '0) begin
      k = LEN_W'(1);
    end else if (kmer_len > LEN_W'(MAX_K)) begin
      k = LEN_W'(MAX_K);
    end else begin
      k = kmer_len;
    end
    sh_mask   = {k, 1'b0};
    sh_high   = {k - LEN_W'(1), 1'b0};
    kmask     = ~({KMER_W{1'b1}} << sh_mask);
    dec       = base_decode(base_char);
    bvalid    = dec[2];
    code      = dec[1:0];
    f0        = first_of_read ? '0 : fwd;
    r0        = first_of_read ? '0 : rev;
    run0      = first_of_read ? '0 : run;
    run_inc   = (run0 < k) ? run0 + LEN_W'(1) : run0;
    fwd_shift = ((f0 << 2) | KMER_W'(code)) & kmask;
    rev_shift = ((KMER_W'(code ^ COMP_XOR) << sh_high) | (r0 >> 2)) & kmask;
    fwd_next  = bvalid ? fwd_shift : f0;
    rev_next  = bvalid ? rev_shift : r0;
    run_next  = bvalid ? run_inc : '0;
    full_next = bvalid && (run_inc >= k);
    canon_next = (fwd_shift < rev_shift) ? fwd_shift : rev_shift;
  end

  assign count_room = count < CNT_W'(SEEN_DEPTH);
  assign count_upd  = count_room ? count + CNT_W'(1) : count;
  assign ovf_upd    = count_room ? overflow : 1'b1;
  assign hit        = cmp_valid && (rd_data == canon);

  always_comb begin
    stat.full_kmer  = full_kmer;
    stat.last       = last_flag;
    stat.count_zero = (count == '0);
    stat.hit        = hit;
    stat.miss_done  = cmp_valid && cmp_last && !hit;
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KMER_LEN_RESET;
    end else if (cfg_wr_en) begin
      kmer_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd      <= '0;
      rev      <= '0;
      run      <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.accept) begin
      fwd <= fwd_next;
      rev <= rev_next;
      run <= run_next;
      if (first_of_read) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end else if (cmd.commit) begin
      count    <= count_upd;
      overflow <= ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      canon     <= canon_next;
      full_kmer <= full_next;
      last_flag <= last_of_read;
    end
  end

  // seen-store search: one read issued per cycle, compared against canon in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (cmd.search_start) begin
      cmp_valid <= 1'b0;
    end else if (cmd.search_step) begin
      cmp_valid <= (ridx < count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      ridx <= '0;
    end else if (cmd.search_step && (ridx < count)) begin
      cmp_last <= (ridx == count - CNT_W'(1));
      ridx     <= ridx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && count_room) begin
      mem[count[SEEN_AW-1:0]] <= canon;
    end
    if (cmd.search_step) begin
      rd_data <= mem[ridx[SEEN_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_kmer || cmd.load_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_kmer) begin
      kmer_value     <= canon;
      distinct_count <= DCOUNT_W'(count_upd);
      read_end       <= 1'b0;
      store_overflow <= ovf_upd;
    end else if (cmd.load_end) begin
      kmer_value     <= '0;
      distinct_count <= DCOUNT_W'(count);
      read_end       <= 1'b1;
      store_overflow <= overflow;
    end
  end

  `CKDE_ASSERT_IMP(a_no_overwrite, cmd.load_kmer || cmd.load_end, !out_valid || out_ready,
                   "output word overwritten")
  `CKDE_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(SEEN_DEPTH), "seen count past depth")
  `CKDE_ASSERT_NXT(a_count_step, cmd.commit && count_room,
                   count == $past(count) + CNT_W'(1), "seen count not advanced on insert")

endmodule

/* hw/rtl/canonical_kmer_dedup_extractor.sv */
`timescale 1ns / 1ps
// Canonical k-mer extractor with per-read duplicate suppression. One ASCII base
// word is taken per input handshake (ACGT in either case are bases, anything else
// breaks the run); once kmer_len bases stand in a row the lesser of the forward
// k-mer and its reverse complement is looked up in a 256-entry seen memory and is
// sent out only if new, followed on the last base of a read by an end word that
// carries the distinct count. Input is taken only while the block is idle. Each
// base goes from idle to a check, which returns to idle if no k-mer is formed;
// a k-mer formed while the store is empty goes straight to output, else the
// store is searched entry by entry until a hit, which drops it, or until every
// stored entry has missed, which puts it out. An end word adds a further output
// step, and a stalled output holds the block until taken. The single-port seen
// memory, read one entry a cycle, sets the search time. Each output word waits
// in a register until taken. kmer_len is written through cfg_wr_en / cfg_wr_data
// and must only change while the block is idle.
module canonical_kmer_dedup_extractor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ckde_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ckde_pkg::CHAR_W-1:0]    base_char,
  input  logic                           first_of_read,
  input  logic                           last_of_read,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ckde_pkg::KMER_W-1:0]    kmer_value,
  output logic [ckde_pkg::DCOUNT_W-1:0]  distinct_count,
  output logic                           read_end,
  output logic                           store_overflow
);
  import ckde_pkg::*;

  ckde_cmd_t  cmd;
  ckde_stat_t stat;

  ckde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ckde_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .base_char      (base_char),
    .first_of_read  (first_of_read),
    .last_of_read   (last_of_read),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kmer_value     (kmer_value),
    .distinct_count (distinct_count),
    .read_end       (read_end),
    .store_overflow (store_overflow),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import ckde_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS = 30;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              fst;
    logic              lst;
  } base_word_t;

  typedef struct {
    logic [KMER_W-1:0]   kmer;
    logic [DCOUNT_W-1:0] cnt;
    logic                fin;
    logic                ovf;
  } kmer_word_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   base_char = '0;
  logic                first_of_read = 1'b0;
  logic                last_of_read = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KMER_W-1:0]   kmer_value;
  logic [DCOUNT_W-1:0] distinct_count;
  logic                read_end;
  logic                store_overflow;

  canonical_kmer_dedup_extractor i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .base_char      (base_char),
    .first_of_read  (first_of_read),
    .last_of_read   (last_of_read),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kmer_value     (kmer_value),
    .distinct_count (distinct_count),
    .read_end       (read_end),
    .store_overflow (store_overflow)
  );

  // predictor state
  logic [LEN_W-1:0] kmer_len_q = KMER_LEN_RESET;
  logic [63:0]      fwd_kmer = '0;
  logic [63:0]      rc_kmer = '0;
  int               run_len = 0;
  logic [63:0]      seen_kmers [SEEN_DEPTH];
  int               seen_cnt = 0;
  logic             seen_ovf = 1'b0;

  base_word_t pending_bases [$];
  kmer_word_t expected_words [$];

  base_word_t nxt_base;
  kmer_word_t want;
  int         send_gap = 0;
  int         recv_stall = 0;
  int         in_gap_pct = 20;
  int         out_stall_pct = 20;
  int         errors = 0;
  int         cycles = 0;
  int         bases_sent = 0;
  int         kmer_words = 0;
  int         end_words = 0;
  int         ovf_words = 0;
  int         dups_dropped = 0;
  int         len_settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_kmer_word(input logic [63:0] kv, input logic fin);
    kmer_word_t w;
    w.kmer = kv[KMER_W-1:0];
    w.cnt  = seen_cnt[DCOUNT_W-1:0];
    w.fin  = fin;
    w.ovf  = seen_ovf;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic predict_kmers(input logic [CHAR_W-1:0] ch, input logic fst, input logic lst);
    int          k;
    int          top_shift;
    logic [63:0] mask;
    logic [1:0]  code;
    logic        is_base;
    logic [63:0] canon;
    logic        hit;
    k = (kmer_len_q == 0) ? 1 : int'(kmer_len_q);
    if (k > MAX_K) k = MAX_K;
    mask = (64'd1 << (2 * k)) - 64'd1;
    top_shift = 2 * (k - 1);
    if (fst) begin
      fwd_kmer = '0;
      rc_kmer  = '0;
      run_len  = 0;
      seen_cnt = 0;
      seen_ovf = 1'b0;
    end
    is_base = 1'b1;
    code = CODE_A;
    case (ch)
      CHAR_A_UC, CHAR_A_LC: code = CODE_A;
      CHAR_C_UC, CHAR_C_LC: code = CODE_C;
      CHAR_G_UC, CHAR_G_LC: code = CODE_G;
      CHAR_T_UC, CHAR_T_LC: code = CODE_T;
      default: is_base = 1'b0;
    endcase
    if (!is_base) begin
      run_len = 0;
    end else begin
      fwd_kmer = ((fwd_kmer << 2) | 64'(code)) & mask;
      rc_kmer  = ((64'(code ^ COMP_XOR) << top_shift) | (rc_kmer >> 2)) & mask;
      if (run_len < k) run_len++;
      if (run_len >= k) begin
        canon = (fwd_kmer < rc_kmer) ? fwd_kmer : rc_kmer;
        hit = 1'b0;
        for (int i = 0; i < seen_cnt; i++) begin
          if (seen_kmers[i] == canon) hit = 1'b1;
        end
        if (hit) begin
          dups_dropped++;
        end else begin
          if (seen_cnt < SEEN_DEPTH) begin
            seen_kmers[seen_cnt] = canon;
            seen_cnt++;
          end else begin
            seen_ovf = 1'b1;
          end
          push_kmer_word(canon, 1'b0);
        end
      end
    end
    if (lst) push_kmer_word(64'd0, 1'b1);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      base_char     <= '0;
      first_of_read <= 1'b0;
      last_of_read  <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_kmers(base_char, first_of_read, last_of_read);
        bases_sent++;
        if ($urandom_range(0, 99) < in_gap_pct) send_gap = gap_len();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bases.size() > 0) begin
          nxt_base = pending_bases.pop_front();
          in_valid      <= 1'b1;
          base_char     <= nxt_base.ch;
          first_of_read <= nxt_base.fst;
          last_of_read  <= nxt_base.lst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected word kmer_value %h read_end %b", $time, kmer_value,
                     read_end);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (want.fin) end_words++;
          else kmer_words++;
          if (want.ovf) ovf_words++;
          if (kmer_value !== want.kmer) begin
            if (errors < MAX_REPORTS)
              $display("%0t: kmer_value expected %h actual %h", $time, want.kmer, kmer_value);
            errors++;
          end
          if (distinct_count !== want.cnt) begin
            if (errors < MAX_REPORTS)
              $display("%0t: distinct_count expected %0d actual %0d", $time, want.cnt,
                       distinct_count);
            errors++;
          end
          if (read_end !== want.fin) begin
            if (errors < MAX_REPORTS)
              $display("%0t: read_end expected %b actual %b", $time, want.fin, read_end);
            errors++;
          end
          if (store_overflow !== want.ovf) begin
            if (errors < MAX_REPORTS)
              $display("%0t: store_overflow expected %b actual %b", $time, want.ovf,
                       store_overflow);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        recv_stall = gap_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] pick_base();
    logic up;
    up = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: return up ? CHAR_A_UC : CHAR_A_LC;
      1: return up ? CHAR_C_UC : CHAR_C_LC;
      2: return up ? CHAR_G_UC : CHAR_G_LC;
      default: return up ? CHAR_T_UC : CHAR_T_LC;
    endcase
  endfunction

  // alph 0: bases with a few ambiguous bytes, 1: A/C only, 2: any byte, 3: bases only
  function automatic logic [CHAR_W-1:0] pick_char(input int alph);
    case (alph)
      0: return ($urandom_range(0, 99) < 4) ? CHAR_W'($urandom_range(0, 255)) : pick_base();
      1: begin
        case ($urandom_range(0, 3))
          0: return CHAR_A_UC;
          1: return CHAR_A_LC;
          2: return CHAR_C_UC;
          default: return CHAR_C_LC;
        endcase
      end
      2: return CHAR_W'($urandom_range(0, 255));
      default: return pick_base();
    endcase
  endfunction

  task automatic add_base(input logic [CHAR_W-1:0] ch, input logic fst, input logic lst);
    base_word_t b;
    b.ch  = ch;
    b.fst = fst;
    b.lst = lst;
    pending_bases.insert(pending_bases.size(), b);
  endtask

  task automatic add_read(input int len, input bit open_start, input bit open_end,
                          input int alph);
    for (int i = 0; i < len; i++)
      add_base(pick_char(alph), (i == 0) && !open_start, (i == len - 1) && !open_end);
  endtask

  task automatic add_phase(input int n_bases);
    int kind;
    // finish the read left open by the previous phase
    add_read($urandom_range(3, 15), 1'b1, 1'b0, 0);
    while (pending_bases.size() < n_bases) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: add_read($urandom_range(1, 40), 1'b0, 1'b0, 0);
        5: add_read($urandom_range(20, 90), 1'b0, 1'b0, 3);
        6: add_read($urandom_range(5, 50), 1'b0, 1'b0, 1);
        7: add_read($urandom_range(1, 20), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 0);
        default: begin
          repeat ($urandom_range(1, 4))
            add_base(pick_char(2), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
    // leave a read open so the next length applies mid-read
    add_read($urandom_range(3, 12), 1'b0, 1'b1, 0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bases.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_kmer_len(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    kmer_len_q = v;
    len_settings++;
  endtask

  initial begin
    logic [LEN_W-1:0] len_plan [10];
    len_plan = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd2, 5'd12, 5'd8, 5'd31, 5'd3, 5'd17};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset length of 20: one full k-mer, a repeat, ambiguous bytes, end word
    @(negedge clk);
    add_base(CHAR_A_UC, 1'b1, 1'b0);
    for (int i = 0; i < 19; i++) add_base(i[0] ? CHAR_A_UC : CHAR_A_LC, 1'b0, 1'b0);
    add_base(CHAR_A_UC, 1'b0, 1'b0);
    add_base(8'h4E, 1'b0, 1'b0);
    add_base(8'h00, 1'b0, 1'b0);
    add_base(8'hFF, 1'b0, 1'b0);
    add_base(CHAR_T_UC, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      write_kmer_len(len_plan[p]);
      in_gap_pct    = (p % 3 == 0) ? 0 : $urandom_range(10, 40);
      out_stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 40);
      @(negedge clk);
      add_phase(80);
      if (p == 5) add_read(320, 1'b0, 1'b0, 3);
      if (p == 7) add_read(290, 1'b0, 1'b0, 3);
      wait_drained();
    end

    $display("covered %0d bases over %0d kmer_len writes (0 to 31), lengths changed mid-read",
             bases_sent, len_settings);
    $display("checked %0d k-mer words, %0d end words, %0d repeats dropped, %0d overflow words",
             kmer_words, end_words, dups_dropped, ovf_words);
    if (errors == 0 && expected_words.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ckde_pkg.sv
hw/rtl/ckde_ctrl.sv
hw/rtl/ckde_dp.sv
hw/rtl/canonical_kmer_dedup_extractor.sv
verif/tb_top.sv
